>>> rtl/kst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, codes and helper functions of the keyword token scanner.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int MAX_SOURCE_BYTES = 65536;
   localparam int MAX_TOKEN_LENGTH = 255;

   localparam int OFS_W = $clog2(MAX_SOURCE_BYTES);
   localparam logic [7:0] LEN_CAP =
      (MAX_TOKEN_LENGTH < 255) ? 8'(MAX_TOKEN_LENGTH) : 8'd255;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Token kinds.
   localparam logic [3:0] KIND_NUMBER  = 4'd0;
   localparam logic [3:0] KIND_IDENT   = 4'd1;
   localparam logic [3:0] KIND_LET     = 4'd2;
   localparam logic [3:0] KIND_PRINT   = 4'd3;
   localparam logic [3:0] KIND_ASSIGN  = 4'd4;
   localparam logic [3:0] KIND_PLUS    = 4'd5;
   localparam logic [3:0] KIND_MINUS   = 4'd6;
   localparam logic [3:0] KIND_STAR    = 4'd7;
   localparam logic [3:0] KIND_SLASH   = 4'd8;
   localparam logic [3:0] KIND_SEMI    = 4'd9;
   localparam logic [3:0] KIND_LPAREN  = 4'd10;
   localparam logic [3:0] KIND_RPAREN  = 4'd11;
   localparam logic [3:0] KIND_UNKNOWN = 4'd12;
   localparam logic [3:0] KIND_EOF     = 4'd13;

   // Open run kinds.
   localparam logic [1:0] RUN_NONE   = 2'd0;
   localparam logic [1:0] RUN_NUMBER = 2'd1;
   localparam logic [1:0] RUN_IDENT  = 2'd2;

   // Keyword prefix tracking.
   localparam logic [2:0] KP_NONE  = 3'd0;
   localparam logic [2:0] KP_LET   = 3'd1;
   localparam logic [2:0] KP_PRINT = 3'd2;

   // Characters.
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
   localparam logic [7:0] CHAR_E      = 8'h65;
   localparam logic [7:0] CHAR_I      = 8'h69;
   localparam logic [7:0] CHAR_L      = 8'h6C;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_P      = 8'h70;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] token_start;
      logic [7:0]  token_length;
      logic [7:0]  token_byte;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] start;
      logic [7:0]  length;
      logic [7:0]  tbyte;
   } token_type;

   // All tokens caused by one input item, in emission order.
   typedef struct packed {
      logic [1:0]           count;
      token_type [2:0]      tok;
   } bundle_type;

   function automatic logic [7:0] let_char(input logic [1:0] pos);
      logic [7:0] ch;
      case (pos)
         2'd0:    ch = CHAR_L;
         2'd1:    ch = CHAR_E;
         2'd2:    ch = CHAR_T;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] print_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = CHAR_P;
         3'd1:    ch = CHAR_R;
         3'd2:    ch = CHAR_I;
         3'd3:    ch = CHAR_N;
         3'd4:    ch = CHAR_T;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [3:0] op_kind(input logic [7:0] ch);
      logic [3:0] k;
      case (ch)
         CHAR_EQUAL:  k = KIND_ASSIGN;
         CHAR_PLUS:   k = KIND_PLUS;
         CHAR_MINUS:  k = KIND_MINUS;
         CHAR_STAR:   k = KIND_STAR;
         CHAR_SLASH:  k = KIND_SLASH;
         CHAR_SEMI:   k = KIND_SEMI;
         CHAR_LPAREN: k = KIND_LPAREN;
         CHAR_RPAREN: k = KIND_RPAREN;
         default:     k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

>>> rtl/kst_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kst_front
// Accepts source bytes, tracks the open run and builds the token bundle
// that each byte causes.
// ----------------------------------------------------------------------------
module kst_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire kst_pkg::req_type     req_payload,
   input  wire logic                 queue_full,
   output logic                      push,
   output kst_pkg::bundle_type       push_data
);
   import kst_pkg::*;

   logic [1:0]       run_kind_ff, run_kind_in;
   logic [15:0]      run_start_ff, run_start_in;
   logic [7:0]       run_length_ff, run_length_in;
   logic [2:0]       kw_prog_ff, kw_prog_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic             discarding_ff, discarding_in;

   logic             accept;
   logic [7:0]       ch;
   logic             is_end, is_digit, is_letter, is_space, extend;
   logic [OFS_W-1:0] offset_next;
   token_type [3:0]  cand;
   logic [3:0]       cand_v;
   bundle_type       bundle;
   logic [2:0]       n;

   function automatic token_type close_tok(input logic [1:0] rk, input logic [2:0] kp,
                                           input logic [15:0] st, input logic [7:0] len);
      token_type t;
      t.start  = st;
      t.length = len;
      t.tbyte  = CHAR_NUL;
      if (rk == RUN_NUMBER) begin
         t.kind = KIND_NUMBER;
      end else if (kp == KP_LET && len == 8'd3) begin
         t.kind = KIND_LET;
      end else if (kp == KP_PRINT && len == 8'd5) begin
         t.kind = KIND_PRINT;
      end else begin
         t.kind = KIND_IDENT;
      end
      return t;
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign ch        = req_payload.data_byte;
   assign is_end    = req_payload.end_of_source;
   assign is_digit  = ch inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_letter = ch inside {[CHAR_UC_A:CHAR_UC_Z], [CHAR_LC_A:CHAR_LC_Z]};
   assign is_space  = ch inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
   assign extend    = (run_kind_ff == RUN_NUMBER && is_digit) ||
                      (run_kind_ff == RUN_IDENT && (is_digit || is_letter));
   assign offset_next = (offset_ff == OFS_W'(MAX_SOURCE_BYTES - 1)) ?
                        '0 : offset_ff + OFS_W'(1);

   always_comb begin
      run_kind_in   = run_kind_ff;
      run_start_in  = run_start_ff;
      run_length_in = run_length_ff;
      kw_prog_in    = kw_prog_ff;
      offset_in     = offset_ff;
      discarding_in = discarding_ff;
      cand_v        = '0;
      cand          = '0;
      if (accept) begin
         if (discarding_ff) begin
            if (is_end) begin
               discarding_in = 1'b0;
               offset_in     = '0;
            end
         end else if (ch == CHAR_NUL) begin
            cand_v[0] = (run_kind_ff != RUN_NONE);
            cand[0]   = close_tok(run_kind_ff, kw_prog_ff, run_start_ff, run_length_ff);
            cand_v[3] = 1'b1;
            cand[3]   = '{kind: KIND_EOF, start: 16'(offset_ff), length: 8'd0,
                          tbyte: CHAR_NUL};
            run_kind_in   = RUN_NONE;
            run_start_in  = '0;
            run_length_in = '0;
            kw_prog_in    = KP_NONE;
            if (is_end) begin
               offset_in = '0;
            end else begin
               discarding_in = 1'b1;
            end
         end else begin
            if (extend) begin
               if (run_kind_ff == RUN_IDENT) begin
                  if (kw_prog_ff == KP_LET &&
                      (run_length_ff >= 8'd3 || ch != let_char(run_length_ff[1:0]))) begin
                     kw_prog_in = KP_NONE;
                  end else if (kw_prog_ff == KP_PRINT &&
                      (run_length_ff >= 8'd5 || ch != print_char(run_length_ff[2:0]))) begin
                     kw_prog_in = KP_NONE;
                  end
               end
               if (run_length_ff < LEN_CAP) begin
                  run_length_in = run_length_ff + 8'd1;
               end
            end else begin
               cand_v[0] = (run_kind_ff != RUN_NONE);
               cand[0]   = close_tok(run_kind_ff, kw_prog_ff, run_start_ff, run_length_ff);
               run_kind_in   = RUN_NONE;
               run_start_in  = '0;
               run_length_in = '0;
               kw_prog_in    = KP_NONE;
               if (is_digit) begin
                  run_kind_in   = RUN_NUMBER;
                  run_start_in  = 16'(offset_ff);
                  run_length_in = 8'd1;
               end else if (is_letter) begin
                  run_kind_in   = RUN_IDENT;
                  run_start_in  = 16'(offset_ff);
                  run_length_in = 8'd1;
                  kw_prog_in    = (ch == CHAR_L) ? KP_LET :
                                  (ch == CHAR_P) ? KP_PRINT : KP_NONE;
               end else if (!is_space) begin
                  cand_v[1] = 1'b1;
                  cand[1]   = '{kind: op_kind(ch), start: 16'(offset_ff), length: 8'd1,
                                tbyte: ch};
               end
            end
            offset_in = offset_next;
            // The end flag closes whatever run is open after this byte.
            if (is_end) begin
               cand_v[2] = (run_kind_in != RUN_NONE);
               cand[2]   = close_tok(run_kind_in, kw_prog_in, run_start_in, run_length_in);
               cand_v[3] = 1'b1;
               cand[3]   = '{kind: KIND_EOF, start: 16'(offset_next), length: 8'd0,
                             tbyte: CHAR_NUL};
               run_kind_in   = RUN_NONE;
               run_start_in  = '0;
               run_length_in = '0;
               kw_prog_in    = KP_NONE;
               offset_in     = '0;
            end
         end
      end
   end

   // Pack the candidate tokens in order; at most three are ever present.
   always_comb begin
      bundle = '0;
      n      = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i] && n < 3'd3) begin
            bundle.tok[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      bundle.count = n[1:0];
   end

   assign push      = accept && (n != 3'd0);
   assign push_data = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff   <= RUN_NONE;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         kw_prog_ff    <= KP_NONE;
         offset_ff     <= '0;
         discarding_ff <= 1'b0;
      end else begin
         run_kind_ff   <= run_kind_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         kw_prog_ff    <= kw_prog_in;
         offset_ff     <= offset_in;
         discarding_ff <= discarding_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/kst_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kst_queue
// Short register queue of token bundles between front and back.
// ----------------------------------------------------------------------------
module kst_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire kst_pkg::bundle_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output kst_pkg::bundle_type       head,
   output logic                      empty
);
   import kst_pkg::*;

   bundle_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/kst_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kst_back
// Walks the tokens of the head bundle and drives them out through an
// output register, one token per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module kst_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kst_pkg::bundle_type  head,
   input  wire logic                 empty,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output kst_pkg::rsp_type          rsp_payload
);
   import kst_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load, is_last;
   token_type  cur;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign cur     = head.tok[idx_ff];
   assign is_last = (idx_ff == head.count - 2'd1);
   assign pop     = load && !empty && is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = !empty;
         if (!empty) begin
            rsp_in = '{token_kind: cur.kind, token_start: cur.start,
                       token_length: cur.length, token_byte: cur.tbyte,
                       last_of_run: is_last};
            idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/keyword_token_scanner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_token_scanner_top
// Byte-serial lexer: source bytes in, number, identifier, keyword, operator,
// unknown and end-of-file tokens out.
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid / req_stall  one source byte and end flag
//   rsp_     out        rsp_valid / rsp_stall  one token with last_of_run
//
// A byte is taken every cycle while the bundle queue (four entries) has room.
// Its tokens leave one per cycle from the output register while rsp_stall is low;
// the first token is registered in a queue entry, then in the output register.
// Reset clears the run state, the queue and the output valid. A stalled output
// fills the queue, then stalls input.
// ----------------------------------------------------------------------------
module keyword_token_scanner_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kst_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kst_pkg::rsp_type       rsp_payload
);
   import kst_pkg::*;

   logic       push, pop, full, empty;
   bundle_type push_data, head;

   kst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (full),
      .push        (push),
      .push_data   (push_data)
   );

   kst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   kst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

>>> tb/keyword_token_scanner_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyword_token_scanner_top_tb
// Self-checking testbench for the byte-serial lexer. Source bytes are fed
// through the request channel while a local scanner model predicts the tokens
// each byte must produce; every token taken from the response channel is
// compared field by field with the oldest prediction. Directed sources cover
// every token kind, keywords, zero bytes and discarding, a saturated run and
// input stalls under a held-off consumer; random sources follow.
// ----------------------------------------------------------------------------
module keyword_token_scanner_top_tb;

   import kst_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS   = 50;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   keyword_token_scanner_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Scanner model state.
   logic [1:0]       run_kind_q  = RUN_NONE;
   logic [15:0]      run_start_q = '0;
   logic [7:0]       run_len_q   = '0;
   logic [2:0]       kw_q        = KP_NONE;
   logic [OFS_W-1:0] offset_q    = '0;
   logic             discard_q   = 1'b0;

   rsp_type    step_tokens[$];
   rsp_type    expected_tokens[$];
   logic [7:0] source_text[$];

   bit          gaps_enabled   = 1'b1;
   int          hold_left      = 0;
   int          error_count    = 0;
   int          tokens_checked = 0;
   int          bytes_sent     = 0;
   int          sources_sent   = 0;
   logic [15:0] kinds_seen     = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d tokens still expected.", expected_tokens.size());
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Scanner model
   // ------------------------------------------------------------------------
   function automatic bit is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= CHAR_LC_A && c <= CHAR_LC_Z) || (c >= CHAR_UC_A && c <= CHAR_UC_Z);
   endfunction

   function automatic bit is_space(logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic [3:0] single_char_kind(logic [7:0] c);
      string ops;
      ops = "=+-*/;()";
      for (int i = 0; i < 8; i++)
         if (c == ops[i]) return 4'(KIND_ASSIGN + i);
      return KIND_UNKNOWN;
   endfunction

   // A keyword candidate survives only while each new byte matches the word
   // at the current run position.
   function automatic logic [2:0] next_keyword(logic [2:0] kp, logic [7:0] pos,
                                               logic [7:0] c);
      string word;
      word = (kp == KP_LET) ? "let" : (kp == KP_PRINT) ? "print" : "";
      if (pos >= word.len() || c != word[pos]) return KP_NONE;
      return kp;
   endfunction

   function automatic void add_token(logic [3:0] kind, logic [15:0] start,
                                     logic [7:0] len, logic [7:0] ch);
      rsp_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.token_byte   = ch;
      t.last_of_run  = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void clear_run();
      run_kind_q  = RUN_NONE;
      run_start_q = '0;
      run_len_q   = '0;
      kw_q        = KP_NONE;
   endfunction

   function automatic void clear_scanner();
      clear_run();
      offset_q  = '0;
      discard_q = 1'b0;
   endfunction

   function automatic void close_open_run();
      logic [3:0] kind;
      if (run_kind_q == RUN_NONE) return;
      if (run_kind_q == RUN_NUMBER) kind = KIND_NUMBER;
      else if (kw_q == KP_LET && run_len_q == 8'd3) kind = KIND_LET;
      else if (kw_q == KP_PRINT && run_len_q == 8'd5) kind = KIND_PRINT;
      else kind = KIND_IDENT;
      add_token(kind, run_start_q, run_len_q, CHAR_NUL);
      clear_run();
   endfunction

   function automatic void open_run(logic [1:0] kind, logic [2:0] kp);
      run_kind_q  = kind;
      run_start_q = offset_q;
      run_len_q   = 8'd1;
      kw_q        = kp;
   endfunction

   // Works out the tokens that one source byte causes and queues them.
   function automatic void lex_byte(req_type item);
      logic [7:0] c;
      logic       eos;
      rsp_type    tail;
      c   = item.data_byte;
      eos = item.end_of_source;
      step_tokens.delete();
      if (discard_q) begin
         if (eos) clear_scanner();
         return;
      end
      if (c == CHAR_NUL) begin
         close_open_run();
         add_token(KIND_EOF, offset_q, 8'd0, CHAR_NUL);
         if (eos) clear_scanner();
         else discard_q = 1'b1;
      end else begin
         if ((run_kind_q == RUN_NUMBER && is_digit(c)) ||
             (run_kind_q == RUN_IDENT && (is_digit(c) || is_letter(c)))) begin
            if (run_kind_q == RUN_IDENT) kw_q = next_keyword(kw_q, run_len_q, c);
            if (run_len_q < LEN_CAP) run_len_q = run_len_q + 8'd1;
         end else begin
            close_open_run();
            if (is_digit(c)) begin
               open_run(RUN_NUMBER, KP_NONE);
            end else if (is_letter(c)) begin
               open_run(RUN_IDENT, (c == CHAR_L) ? KP_LET : (c == CHAR_P) ? KP_PRINT : KP_NONE);
            end else if (!is_space(c)) begin
               add_token(single_char_kind(c), offset_q, 8'd1, c);
            end
         end
         if (int'(offset_q) + 1 >= MAX_SOURCE_BYTES) offset_q = '0;
         else offset_q = offset_q + 1'b1;
         if (eos) begin
            close_open_run();
            add_token(KIND_EOF, offset_q, 8'd0, CHAR_NUL);
            clear_scanner();
         end
      end
      if (step_tokens.size() > 0) begin
         tail = step_tokens.pop_back();
         tail.last_of_run = 1'b1;
         step_tokens.push_back(tail);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Response side: consumer stalls and token checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= gaps_enabled && ($urandom_range(99) < 15);
      end
   end

   function automatic void check_field(string name, int got, int want);
      if (got != want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: token %0d %s mismatch: expected %0d, got %0d",
                     $time, tokens_checked, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : token_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         kinds_seen[rsp_payload.token_kind] = 1'b1;
         if (expected_tokens.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: unexpected token: expected none, got kind %0d start %0d",
                        $time, rsp_payload.token_kind, rsp_payload.token_start);
         end else begin
            want = expected_tokens.pop_front();
            check_field("kind", rsp_payload.token_kind, want.token_kind);
            check_field("start", rsp_payload.token_start, want.token_start);
            check_field("length", rsp_payload.token_length, want.token_length);
            check_field("byte", rsp_payload.token_byte, want.token_byte);
            check_field("last_of_run", rsp_payload.last_of_run, want.last_of_run);
         end
         tokens_checked++;
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic feed_byte(input logic [7:0] b, input logic eos);
      req_type item;
      item.data_byte     = b;
      item.end_of_source = eos;
      while (gaps_enabled && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      lex_byte(item);
      bytes_sent++;
      if (eos) sources_sent++;
   endtask

   function automatic void append_char(logic [7:0] c);
      source_text.push_back(c);
   endfunction

   function automatic void append_text(string s);
      for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
   endfunction

   // Sends the collected source; the end flag rides on its last byte if asked.
   task automatic feed_source(input bit close);
      for (int i = 0; i < source_text.size(); i++)
         feed_byte(source_text[i], close && (i == source_text.size() - 1));
      source_text.delete();
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_letter();
      return 8'(($urandom_range(1) ? CHAR_LC_A : CHAR_UC_A) + $urandom_range(25));
   endfunction

   function automatic logic [7:0] random_digit();
      return 8'(CHAR_ZERO + $urandom_range(9));
   endfunction

   function automatic string keyword_like();
      case ($urandom_range(9))
         0:       return "let";
         1:       return "print";
         2:       return "le";
         3:       return "lets";
         4:       return "prin";
         5:       return "printer";
         6:       return "Let";
         7:       return "pr1nt";
         8:       return "print7";
         default: return "letprint";
      endcase
   endfunction

   function automatic logic [7:0] random_unknown();
      string others;
      others = "!#$%&',.:<>?@[]^_{|}~";
      case ($urandom_range(2))
         0:       return others[$urandom_range(others.len() - 1)];
         1:       return 8'($urandom_range(128, 255));
         default: return $urandom_range(1) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(14, 31));
      endcase
   endfunction

   // Builds a source of mostly well-formed lexemes; noisy sources also carry
   // arbitrary bytes, zero included.
   function automatic void build_random_source(int target_len, bit noisy);
      string ops;
      ops = "=+-*/;()";
      while (source_text.size() < target_len) begin
         case ($urandom_range(noisy ? 9 : 8))
            0: append_text(keyword_like());
            1, 2: begin
               append_char(random_letter());
               repeat ($urandom_range(6))
                  append_char(($urandom_range(3) == 0) ? random_digit() : random_letter());
            end
            3: repeat ($urandom_range(1, 5)) append_char(random_digit());
            4, 5: append_char(ops[$urandom_range(7)]);
            6, 7: append_char($urandom_range(2) == 0 ? 8'($urandom_range(9, 13)) : CHAR_SPACE);
            8: append_char(random_unknown());
            default: append_char(8'($urandom_range(255)));
         endcase
      end
      if ($urandom_range(4) == 0) begin
         append_char(CHAR_NUL);
         repeat ($urandom_range(3)) append_char(8'($urandom_range(255)));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_token_kinds();
      append_text("let print\t7q=+-*/;()");
      append_char(8'h80);
      append_char(8'hFF);
      append_char(CHAR_CR);
      // The final byte closes an identifier, forms an operator and ends the source.
      append_text("x(");
      feed_source(1'b1);
      wait_idle();
   endtask

   task automatic test_zero_byte();
      append_text("1");
      append_char(CHAR_NUL);
      append_text("zz");
      append_char(CHAR_NUL);
      feed_source(1'b0);
      // The end flag on a discarded byte only restarts the scanner.
      feed_byte(CHAR_UC_A, 1'b1);
      feed_byte(CHAR_NUL, 1'b1);
      append_text("ab");
      append_char(CHAR_NUL);
      feed_source(1'b1);
      wait_idle();
   endtask

   task automatic test_long_runs();
      // An identifier one byte longer than the length cap.
      append_text("print");
      repeat (251) append_char($urandom_range(1) ? random_letter() : random_digit());
      append_char(CHAR_SPACE);
      append_char(random_digit());
      feed_source(1'b1);
      wait_idle();
   endtask

   task automatic test_backpressure();
      gaps_enabled = 1'b0;
      hold_left    = 80;
      repeat (3) append_text("x=(y1+22)*3; ");
      feed_source(1'b1);
      wait_idle();
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_sources();
      int first_byte;
      first_byte   = bytes_sent;
      gaps_enabled = 1'b0;
      build_random_source(16, 1'b0);
      feed_source(1'b1);
      gaps_enabled = 1'b1;
      while (bytes_sent - first_byte < 40) begin
         build_random_source($urandom_range(4, 12), $urandom_range(3) == 0);
         feed_source(1'b1);
      end
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_token_kinds();
      test_zero_byte();
      test_long_runs();
      test_backpressure();
      test_random_sources();
      wait_idle();
      $display("Fed %0d bytes in %0d sources and checked %0d tokens.",
               bytes_sent, sources_sent, tokens_checked);
      $display("%0d of 14 token kinds appeared, with zero-byte discards, a saturated run",
               $countones(kinds_seen));
      $display("and a long consumer hold-off that filled the queue among the cases.");
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/kst_pkg.sv
rtl/kst_front.sv
rtl/kst_queue.sv
rtl/kst_back.sv
rtl/keyword_token_scanner_top.sv
tb/keyword_token_scanner_top_tb.sv
